// ===== design/rsi_pkg.sv =====
// shared types and constants for the radix string-to-integer parser
// no dependencies; every other design file imports this package
package rsi_pkg;

  localparam int CHAR_W      = 8;
  localparam int VALUE_W     = 64;
  localparam int RADIX_W     = 5;
  localparam int TARGET_W    = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 5;
  // product of the accumulator and a radix of at most 16, plus a digit
  localparam int PROD_W      = VALUE_W + RADIX_W;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIX_SELECT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_KIND  = 1'b1;

  localparam logic [RADIX_W-1:0]  RADIX_SELECT_RESET = 5'd0;
  localparam logic [TARGET_W-1:0] TARGET_KIND_RESET  = 3'd3;

  // radix codes
  localparam logic [RADIX_W-1:0] RADIX_NONE = 5'd0;
  localparam logic [RADIX_W-1:0] RADIX_2    = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_8    = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_10   = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_16   = 5'd16;

  // target kind: bit 2 marks signed, bits 1:0 select 8/16/32/64 bits
  localparam int TK_SIGNED_BIT = 2;
  localparam logic [1:0] TK_W8  = 2'd0;
  localparam logic [1:0] TK_W16 = 2'd1;
  localparam logic [1:0] TK_W32 = 2'd2;
  localparam logic [1:0] TK_W64 = 2'd3;

  // characters
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              char_present;
    logic              last;
  } rsi_item_t;

  typedef struct packed {
    logic [RADIX_W-1:0]  radix_select;
    logic [TARGET_W-1:0] target_kind;
  } rsi_cfg_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } rsi_digit_t;

endpackage

// ===== design/rsi_if.sv =====
// handshake interfaces for the character stream and the result stream
// depends on rsi_pkg
interface rsi_char_if import rsi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              char_present;
  logic              last;

  modport source (output valid, char_code, char_present, last, input ready);
  modport sink   (input valid, char_code, char_present, last, output ready);
endinterface

interface rsi_result_if import rsi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [VALUE_W-1:0] value;

  modport source (output valid, ok, value, input ready);
  modport sink   (input valid, ok, value, output ready);
endinterface

// ===== design/rsi_in_reg.sv =====
// input register for the character stream
// depends on rsi_pkg and rsi_char_if
module rsi_in_reg import rsi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  rsi_char_if.sink          chars,
  input  logic              take,
  output logic              item_valid,
  output rsi_item_t         item
);

  assign chars.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      item.char_code    <= chars.char_code;
      item.char_present <= chars.char_present;
      item.last         <= chars.last;
    end
  end

endmodule

// ===== design/rsi_digit_decode.sv =====
// maps one ASCII character to a hex digit value, or flags it as no digit
// depends on rsi_pkg
module rsi_digit_decode import rsi_pkg::*; (
  input  logic [CHAR_W-1:0] char_code,
  output rsi_digit_t        digit
);

  logic [CHAR_W-1:0] lower;

  always_comb begin
    lower = char_code;
    if (char_code >= CH_UA && char_code <= CH_UZ) begin
      lower = char_code | CASE_BIT;
    end
    digit.bad = 1'b0;
    digit.val = 4'd0;
    if (char_code >= CH_0 && char_code <= CH_9) begin
      digit.val = 4'(char_code - CH_0);
    end else if (lower >= CH_LA && lower <= CH_LF) begin
      digit.val = 4'(8'd10 + (lower - CH_LA));
    end else begin
      digit.bad = 1'b1;
    end
  end

endmodule

// ===== design/rsi_core.sv =====
// parse state, per-character update, range check and result register
// depends on rsi_pkg, rsi_result_if and rsi_digit_decode
module rsi_core import rsi_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rsi_cfg_t   cfg,
  input  logic       item_valid,
  input  rsi_item_t  item,
  output logic       take,
  rsi_result_if.source results
);

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_SIGNED = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } rsi_phase_t;

  rsi_phase_t         phase, phase_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic               negative, negative_next;
  logic [RADIX_W-1:0] radix, radix_next;
  logic               failed, failed_next;

  logic               out_valid;
  logic               out_ok;
  logic [VALUE_W-1:0] out_value;
  logic               ok_next;
  logic [VALUE_W-1:0] value_next;

  rsi_digit_t         digit;
  logic               radix_ok;
  logic               start_prefix;
  logic               do_latch;
  logic               do_digit;
  logic [RADIX_W-1:0] detected;
  logic [PROD_W-1:0]  prod;
  logic               fin_fail;
  logic [VALUE_W-1:0] umax;
  logic [VALUE_W-1:0] smax;
  logic               tk_signed;

  rsi_digit_decode u_digit (
    .char_code (item.char_code),
    .digit     (digit)
  );

  assign radix_ok = (cfg.radix_select == RADIX_NONE) ||
                    (cfg.radix_select >= RADIX_2 && cfg.radix_select <= RADIX_16);
  assign tk_signed = cfg.target_kind[TK_SIGNED_BIT];

  // a non-final word never waits on the result side
  assign take = item_valid && (!item.last || !out_valid || results.ready);

  always_comb begin
    case (cfg.target_kind[1:0])
      TK_W8:   umax = 64'h0000_0000_0000_00FF;
      TK_W16:  umax = 64'h0000_0000_0000_FFFF;
      TK_W32:  umax = 64'h0000_0000_FFFF_FFFF;
      TK_W64:  umax = 64'hFFFF_FFFF_FFFF_FFFF;
      default: umax = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    smax = umax >> 1;
  end

  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    negative_next = negative;
    radix_next    = radix;
    failed_next   = failed;
    start_prefix  = 1'b0;
    do_latch      = 1'b0;
    do_digit      = 1'b0;
    detected      = RADIX_NONE;
    prod          = '0;
    fin_fail      = 1'b0;
    ok_next       = 1'b0;
    value_next    = '0;

    if (item.char_present && !failed) begin
      case (phase)
        PH_START: begin
          if (item.char_code == CH_PLUS) begin
            phase_next = PH_SIGNED;
          end else if (item.char_code == CH_MINUS) begin
            if (tk_signed) begin
              negative_next = 1'b1;
              phase_next    = PH_SIGNED;
            end else begin
              failed_next = 1'b1;
            end
          end else begin
            start_prefix = 1'b1;
          end
        end
        PH_SIGNED: start_prefix = 1'b1;
        PH_ZERO: begin
          phase_next = PH_DIGITS;
          do_latch   = 1'b1;
          if (item.char_code == CH_LX) begin
            detected = RADIX_16;
          end else if (item.char_code == CH_LB) begin
            detected = RADIX_2;
          end else begin
            detected = RADIX_8;
            do_digit = 1'b1;
          end
        end
        PH_DIGITS: do_digit = 1'b1;
        default: ;
      endcase

      if (start_prefix) begin
        if (item.char_code == CH_0) begin
          phase_next = PH_ZERO;
        end else begin
          phase_next = PH_DIGITS;
          do_latch   = 1'b1;
          do_digit   = 1'b1;
          if (item.char_code >= CH_1 && item.char_code <= CH_9) begin
            detected = RADIX_10;
          end
        end
      end
    end

    // a forced radix overrides the one the prefix implies
    if (do_latch) begin
      if (!radix_ok) begin
        failed_next = 1'b1;
      end else begin
        radix_next = (cfg.radix_select != RADIX_NONE) ? cfg.radix_select : detected;
        if (radix_next == RADIX_NONE) begin
          failed_next = 1'b1;
        end
      end
    end

    if (do_digit && !failed_next) begin
      prod = {{RADIX_W{1'b0}}, acc} * {{VALUE_W{1'b0}}, radix_next}
             + {{(PROD_W-4){1'b0}}, digit.val};
      if (radix_next < RADIX_2 || digit.bad || {1'b0, digit.val} >= radix_next ||
          (|prod[PROD_W-1:VALUE_W])) begin
        failed_next = 1'b1;
      end else begin
        acc_next = prod[VALUE_W-1:0];
      end
    end

    // end of string: settle an unresolved prefix, then check the range
    fin_fail = failed_next;
    if (phase_next == PH_START || phase_next == PH_SIGNED) begin
      if (!radix_ok || cfg.radix_select == RADIX_NONE) begin
        fin_fail = 1'b1;
      end
    end else if (phase_next == PH_ZERO) begin
      if (!radix_ok) begin
        fin_fail = 1'b1;
      end
    end
    if (!fin_fail) begin
      if (!tk_signed) begin
        ok_next    = !(|(acc_next & ~umax));
        value_next = acc_next;
      end else if (negative_next) begin
        ok_next    = !(|(acc_next & ~smax)) || (acc_next == smax + 64'd1);
        value_next = '0 - acc_next;
      end else begin
        ok_next    = !(|(acc_next & ~smax));
        value_next = acc_next;
      end
    end
    if (!ok_next) begin
      value_next = '0;
    end

    if (item.last) begin
      phase_next    = PH_START;
      acc_next      = '0;
      negative_next = 1'b0;
      radix_next    = RADIX_NONE;
      failed_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      acc      <= '0;
      negative <= 1'b0;
      radix    <= RADIX_NONE;
      failed   <= 1'b0;
    end else if (take) begin
      phase    <= phase_next;
      acc      <= acc_next;
      negative <= negative_next;
      radix    <= radix_next;
      failed   <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && item.last) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last) begin
      out_ok    <= ok_next;
      out_value <= value_next;
    end
  end

  assign results.valid = out_valid;
  assign results.ok    = out_ok;
  assign results.value = out_value;

endmodule

// ===== design/radix_string_to_integer.sv =====
// Streaming radix string-to-integer parser: one ASCII character per word
// on chars, one result word on results for each word marked last. Every
// word passes an input register and then the update logic (digit
// decode, a 64 by 5 bit multiply-add and the overflow and range checks),
// so the block takes one word per clock; a finished result sits in an
// output register and only the next last word waits for it to be taken.
// Registers are written through cfg_write/cfg_index/cfg_data: index 0 is
// radix_select (0 detects from the prefix, 2..16 forces), index 1 is
// target_kind (0..3 unsigned 8..64 bits, 4..7 signed 8..64 bits).
// Depends on rsi_pkg, rsi_if, rsi_in_reg, rsi_digit_decode and rsi_core.
module radix_string_to_integer import rsi_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  rsi_char_if.sink               chars,
  rsi_result_if.source           results
);

  rsi_cfg_t  cfg;
  logic      item_valid;
  rsi_item_t item;
  logic      take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix_select <= RADIX_SELECT_RESET;
      cfg.target_kind  <= TARGET_KIND_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RADIX_SELECT: cfg.radix_select <= cfg_data;
        CFG_TARGET_KIND:  cfg.target_kind  <= cfg_data[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  rsi_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  rsi_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .results    (results)
  );

endmodule
